/* rtl/core/rgb_hsl_pkg.sv */
package rgb_hsl_pkg;

  localparam int REM_W = 11;

  localparam logic [REM_W-1:0] LIGHT_DEN = REM_W'(510);
  localparam logic [8:0] SUM_HALF = 9'd255;
  localparam logic [8:0] SUM_FULL = 9'd510;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

  // one restoring step: shift in a numerator bit, subtract if it fits
  function automatic logic [REM_W:0] div_step(
    input logic [REM_W-1:0] rem,
    input logic             nbit,
    input logic [REM_W-1:0] den
  );
    logic [REM_W:0] t;
    logic [REM_W:0] res;
    t = {rem, nbit};
    if (t >= {1'b0, den}) begin
      res = {1'b1, REM_W'(t - {1'b0, den})};
    end else begin
      res = {1'b0, t[REM_W-1:0]};
    end
    return res;
  endfunction

endpackage

/* rtl/core/rgb_to_hsl_unit.sv */
// RGB to HSL converter, one pixel per clock while the output is not stalled.
//
// Input channel: red, green, blue with pixel_valid / pixel_ready. A word is
// taken at a rising edge where both are high.
// Output channel: hue, saturation, lightness with hsl_valid / hsl_ready.
// hue is a fraction of a full turn times 2^FRACTION_BITS; saturation and
// lightness are fractions times 2^FRACTION_BITS - 1, all truncated.
//
// Pipeline: a min/max stage, a setup stage, then FRACTION_BITS long-division
// stages, each producing one quotient bit for all three results at once.
// Throughput is one word per cycle while the receiver is not stalling.
//
// Each stage holds its own valid bit and advances whenever the stage after
// it is empty or moving, so bubbles close up while the receiver stalls and
// the input keeps accepting until every stage is full. The output word stays
// put until taken. Reset empties the pipeline; no pixel is in flight after it.
module rgb_to_hsl_unit
  import rgb_hsl_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pixel_valid,
  output logic                     pixel_ready,
  input  logic [7:0]               red,
  input  logic [7:0]               green,
  input  logic [7:0]               blue,
  output logic                     hsl_valid,
  input  logic                     hsl_ready,
  output logic [FRACTION_BITS-1:0] hue,
  output logic [FRACTION_BITS-1:0] saturation,
  output logic [FRACTION_BITS-1:0] lightness
);

  localparam int F  = FRACTION_BITS;
  localparam int XW = FRACTION_BITS + 9;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [F-1:0]     xlo;
    logic [F-1:0]     q;
  } lane_t;

  typedef struct packed {
    lane_t            hue;
    lane_t            sat;
    lane_t            lit;
    logic [REM_W-1:0] hue_den;
    logic [REM_W-1:0] sat_den;
  } stage_t;

  // min/max stage
  logic       p0_valid;
  logic       p0_ready;
  logic [7:0] p0_red;
  logic [7:0] p0_green;
  logic [7:0] p0_blue;
  logic [7:0] p0_delta;
  logic [8:0] p0_sum;
  max_sel_t   p0_sel;

  logic [7:0] mx;
  logic [7:0] mn;
  max_sel_t   sel;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    priority if (red >= green && red >= blue) begin
      sel = SEL_RED;
    end else if (green >= blue) begin
      sel = SEL_GREEN;
    end else begin
      sel = SEL_BLUE;
    end
  end

  // division pipeline, index 0 is the setup stage
  stage_t     stg       [0:F];
  logic [F:0] stg_valid;
  logic [F:0] stg_ready;

  always_comb begin
    stg_ready[F] = !stg_valid[F] || hsl_ready;
    for (int k = F - 1; k >= 0; k--) begin
      stg_ready[k] = !stg_valid[k] || stg_ready[k+1];
    end
  end

  assign p0_ready    = !p0_valid || stg_ready[0];
  assign pixel_ready = p0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (p0_ready) begin
      p0_valid <= pixel_valid;
    end
    if (p0_ready && pixel_valid) begin
      p0_red   <= red;
      p0_green <= green;
      p0_blue  <= blue;
      p0_delta <= mx - mn;
      p0_sum   <= {1'b0, mx} + {1'b0, mn};
      p0_sel   <= sel;
    end
  end

  // setup: numerators and divisors
  logic [REM_W-1:0] d11;
  logic [REM_W-1:0] r11;
  logic [REM_W-1:0] g11;
  logic [REM_W-1:0] b11;
  logic [REM_W-1:0] den6;
  logic [REM_W-1:0] hue_num;
  logic [XW-1:0]    xs;
  logic [XW-1:0]    xl;
  stage_t           setup;

  always_comb begin
    d11  = REM_W'(p0_delta);
    r11  = REM_W'(p0_red);
    g11  = REM_W'(p0_green);
    b11  = REM_W'(p0_blue);
    den6 = (d11 << 2) + (d11 << 1);

    unique case (p0_sel)
      SEL_RED: begin
        if (g11 >= b11) begin
          hue_num = g11 - b11;
        end else begin
          hue_num = den6 - (b11 - g11);
        end
      end
      SEL_GREEN: hue_num = (d11 << 1) + b11 - r11;
      SEL_BLUE:  hue_num = (d11 << 2) + r11 - g11;
      default:   hue_num = '0;
    endcase

    // x * (2^F - 1) = (x << F) - x
    xs = (XW'(p0_delta) << F) - XW'(p0_delta);
    xl = (XW'(p0_sum) << F) - XW'(p0_sum);

    setup.hue.rem = hue_num;
    setup.hue.xlo = '0;
    setup.hue.q   = '0;
    setup.sat.rem = REM_W'(xs[XW-1:F]);
    setup.sat.xlo = xs[F-1:0];
    setup.sat.q   = '0;
    setup.lit.rem = REM_W'(xl[XW-1:F]);
    setup.lit.xlo = xl[F-1:0];
    setup.lit.q   = '0;

    // grey pixel: zero numerators, any nonzero divisor gives zero
    if (p0_delta == 8'd0) begin
      setup.hue_den = REM_W'(1);
      setup.sat_den = REM_W'(1);
    end else begin
      setup.hue_den = den6;
      if (p0_sum < SUM_HALF) begin
        setup.sat_den = REM_W'(p0_sum);
      end else begin
        setup.sat_den = REM_W'(SUM_FULL - p0_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (stg_ready[0]) begin
      stg_valid[0] <= p0_valid;
    end
    if (stg_ready[0] && p0_valid) begin
      stg[0] <= setup;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_div
    logic [REM_W:0] hs;
    logic [REM_W:0] ss;
    logic [REM_W:0] ls;
    stage_t         nxt;

    always_comb begin
      hs = div_step(stg[k-1].hue.rem, stg[k-1].hue.xlo[F-1], stg[k-1].hue_den);
      ss = div_step(stg[k-1].sat.rem, stg[k-1].sat.xlo[F-1], stg[k-1].sat_den);
      ls = div_step(stg[k-1].lit.rem, stg[k-1].lit.xlo[F-1], LIGHT_DEN);

      nxt         = stg[k-1];
      nxt.hue.rem = hs[REM_W-1:0];
      nxt.hue.xlo = stg[k-1].hue.xlo << 1;
      nxt.hue.q   = {stg[k-1].hue.q[F-2:0], hs[REM_W]};
      nxt.sat.rem = ss[REM_W-1:0];
      nxt.sat.xlo = stg[k-1].sat.xlo << 1;
      nxt.sat.q   = {stg[k-1].sat.q[F-2:0], ss[REM_W]};
      nxt.lit.rem = ls[REM_W-1:0];
      nxt.lit.xlo = stg[k-1].lit.xlo << 1;
      nxt.lit.q   = {stg[k-1].lit.q[F-2:0], ls[REM_W]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else if (stg_ready[k]) begin
        stg_valid[k] <= stg_valid[k-1];
      end
      if (stg_ready[k] && stg_valid[k-1]) begin
        stg[k] <= nxt;
      end
    end
  end

  assign hsl_valid  = stg_valid[F];
  assign hue        = stg[F].hue.q;
  assign saturation = stg[F].sat.q;
  assign lightness  = stg[F].lit.q;

endmodule

/* test/rgb_to_hsl_checker.sv */
module rgb_to_hsl_checker
  import rgb_hsl_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pixel_valid,
  input  logic                     pixel_ready,
  input  logic [7:0]               red,
  input  logic [7:0]               green,
  input  logic [7:0]               blue,
  input  logic                     hsl_valid,
  input  logic                     hsl_ready,
  input  logic [FRACTION_BITS-1:0] hue,
  input  logic [FRACTION_BITS-1:0] saturation,
  input  logic [FRACTION_BITS-1:0] lightness,
  output int                       failures,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] sat;
    logic [FRACTION_BITS-1:0] light;
  } hsl_t;

  hsl_t hsl_expected [$];
  int   fail_total = 0;

  assign failures = fail_total;
  assign pending  = hsl_expected.size();

  function automatic hsl_t hsl_of_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    longint unsigned full, mask, top, bottom, spread, total, den;
    longint          num;
    max_sel_t        winner;
    hsl_t            res;
    full   = 64'd1 << FRACTION_BITS;
    mask   = full - 1;
    top    = r;
    bottom = r;
    winner = SEL_RED;
    if (g > top) begin
      top    = g;
      winner = SEL_GREEN;
    end
    if (b > top) begin
      top    = b;
      winner = SEL_BLUE;
    end
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    spread = top - bottom;
    total  = top + bottom;
    res.light = FRACTION_BITS'((total * mask) / 510);
    res.hue   = '0;
    res.sat   = '0;
    if (spread != 0) begin
      den = 6 * spread;
      if (total < 255) res.sat = FRACTION_BITS'((spread * mask) / total);
      else res.sat = FRACTION_BITS'((spread * mask) / (510 - total));
      case (winner)
        SEL_RED:   num = longint'(g) - longint'(b);
        SEL_GREEN: num = longint'(2 * spread) + longint'(b) - longint'(r);
        default:   num = longint'(4 * spread) + longint'(r) - longint'(g);
      endcase
      if (num < 0) num += longint'(den);
      res.hue = FRACTION_BITS'((longint'(num) * full) / den);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    hsl_t want;
    if (!rst) begin
      if (pixel_valid && pixel_ready) hsl_expected.push_back(hsl_of_pixel(red, green, blue));
      if (hsl_valid && hsl_ready) begin
        if (hsl_expected.size() == 0) begin
          $display("%t unexpected word hue %h sat %h light %h", $time, hue, saturation,
                   lightness);
          fail_total++;
        end else begin
          want = hsl_expected.pop_front();
          if (hue !== want.hue) begin
            $display("%t hue expected %h actual %h", $time, want.hue, hue);
            fail_total++;
          end
          if (saturation !== want.sat) begin
            $display("%t saturation expected %h actual %h", $time, want.sat, saturation);
            fail_total++;
          end
          if (lightness !== want.light) begin
            $display("%t lightness expected %h actual %h", $time, want.light, lightness);
            fail_total++;
          end
        end
      end
    end
  end

endmodule

/* test/rgb_to_hsl_unit_test.sv */
module rgb_to_hsl_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = 16;
  localparam int STALL_MAX  = 5000;
  localparam int HOLD_LEN   = 400;
  localparam int N_CORNERS  = 23;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            pixel_valid = 1'b0;
  logic            pixel_ready;
  logic [7:0]      red = '0;
  logic [7:0]      green = '0;
  logic [7:0]      blue = '0;
  logic            hsl_valid;
  logic            hsl_ready = 1'b0;
  logic [FRAC-1:0] hue, saturation, lightness;

  int failures, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold = 1'b0;
  int quiet_cycles = 0;

  // RRGGBB
  logic [23:0] corner_pixels [N_CORNERS] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010000, 24'hFEFFFF, 24'hC80A32,
    24'hFF0001, 24'hFFFE00, 24'h0AC864, 24'h6432C8, 24'h7F0000, 24'hFE0000,
    24'h807F7F, 24'h7F8080, 24'hAA5500, 24'h0001FF, 24'h01FF00
  };

  rgb_to_hsl_unit #(.FRACTION_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue),
    .hsl_valid(hsl_valid), .hsl_ready(hsl_ready),
    .hue(hue), .saturation(saturation), .lightness(lightness)
  );

  rgb_to_hsl_checker #(.FRACTION_BITS(FRAC)) hsl_check (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue),
    .hsl_valid(hsl_valid), .hsl_ready(hsl_ready),
    .hue(hue), .saturation(saturation), .lightness(lightness),
    .failures(failures), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver; a long hold lets the pipe fill and back up the input
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        hsl_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        hsl_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && pixel_ready) || (hsl_valid && hsl_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_MAX) begin
      $display("** rgb_to_hsl_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [23:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red         <= rgb[23:16];
    green       <= rgb[15:8];
    blue        <= rgb[7:0];
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    logic [7:0] v;
    case ($urandom_range(3))
      0: v = 8'(($urandom_range(1) != 0) ? 255 - $urandom_range(2) : $urandom_range(2));
      1: v = 8'($urandom_range(120, 135));
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  function automatic logic [23:0] pick_pixel();
    logic [7:0] a;
    case ($urandom_range(7))
      0: begin
        a = 8'($urandom_range(255));
        return {a, a, a};
      end
      1: begin
        a = pick_level();
        case ($urandom_range(2))
          0: return {a, a, pick_level()};
          1: return {a, pick_level(), a};
          default: return {pick_level(), a, a};
        endcase
      end
      2: return {pick_level(), pick_level(), pick_level()};
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic run_phase(input int items, input int idle, input int stall,
                           input bit squeeze);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (squeeze) long_hold = 1'b1;
    repeat (items) send_pixel(pick_pixel());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    run_phase(250, 0, 0, 1'b0);
    run_phase(250, 86, 0, 1'b0);
    run_phase(250, 0, 86, 1'b0);
    run_phase(250, 21, 21, 1'b0);
    run_phase(200, 0, 0, 1'b1);
    run_phase(200, 0, 0, 1'b0);
    pixel_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (FRAC + 6) @(posedge clk);
    if (failures == 0) begin
      $display("** rgb_to_hsl_unit: PASSED **");
    end else begin
      $display("** rgb_to_hsl_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rgb_hsl_pkg.sv
rtl/core/rgb_to_hsl_unit.sv
test/rgb_to_hsl_checker.sv
test/rgb_to_hsl_unit_test.sv
